FILE: rtl/core/pla_pkg.sv
// Shared widths, configuration register codes and sideband structs of the
// point light attenuation block. No dependencies.
package pla_pkg;

	localparam int COORD_W    = 32;
	localparam int MAG_W      = 32;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int SUM_W      = SQ_W + 2;
	localparam int SQRT_SHIFT = 28;
	localparam int RAD_W      = SUM_W + SQRT_SHIFT;
	localparam int ROOT_W     = 47;
	localparam int DIST_SHIFT = 14;
	localparam int DIST_W     = 32;
	localparam int DIR_W      = 16;
	localparam int CH_W       = 16;
	localparam int RGB_W      = 3 * CH_W;
	localparam int COEF_W     = 32;
	localparam int ATT_W      = 98;
	localparam int ATT_DEN_W  = 64;
	localparam int DIV_Q_W    = 16;
	localparam int DIR_NUM_W  = MAG_W + SQRT_SHIFT;
	localparam int COL_SHIFT  = 48;
	localparam int COL_NUM_W  = CH_W + COL_SHIFT;
	localparam int DIR_ONE    = 16384;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTENSITY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CONST     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LINEAR    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_QUAD      = 3'd6;

	localparam logic [RGB_W-1:0]  INTENSITY_RST = 48'h0100_0100_0100;
	localparam logic [COEF_W-1:0] CONST_RST     = 32'h0001_0000;

	// Magnitudes and signs of the point-to-light vector.
	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
	} pla_vec_t;

	// Attenuation summary handed to the colour divider.
	typedef struct packed {
		logic                 nonpos;
		logic                 big;
		logic [ATT_DEN_W-1:0] den;
		logic [DIST_W-1:0]    dist_sat;
	} pla_att_t;

endpackage

FILE: rtl/core/pla_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on pla_pkg.
module pla_sqrt import pla_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [RAD_W-1:0]  rad,
	input  pla_vec_t          in_vec,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root,
	output pla_vec_t          out_vec
);
	localparam int REM_W = RAD_W + 2;

	logic              vld_s  [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	pla_vec_t          vec_s  [ROOT_W];

	for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
		localparam int K = ROOT_W - 1 - j;
		logic              vld_in;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		pla_vec_t          vec_in;
		logic [REM_W-1:0]  trial;

		if (j == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = REM_W'(rad);
			assign root_in = '0;
			assign vec_in  = in_vec;
		end else begin : g_next
			assign vld_in  = vld_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign root_in = root_s[j-1];
			assign vec_in  = vec_s[j-1];
		end

		// (r + 2^K)^2 - r^2 = r * 2^(K+1) + 2^(2K)
		assign trial = (REM_W'(root_in) << (K + 1)) + (REM_W'(1) << (2 * K));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vec_s[j] <= vec_in;
				if (rem_in >= trial) begin
					rem_s[j]  <= rem_in - trial;
					root_s[j] <= root_in | (ROOT_W'(1) << K);
				end else begin
					rem_s[j]  <= rem_in;
					root_s[j] <= root_in;
				end
			end
		end
	end

	assign out_valid = vld_s[ROOT_W-1];
	assign root      = root_s[ROOT_W-1];
	assign out_vec   = vec_s[ROOT_W-1];

endmodule

FILE: rtl/core/pla_atten.sv
// Three-stage attenuation pipeline: distance, products, exact sum.
// Depends on pla_pkg.
module pla_atten import pla_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [ROOT_W-1:0]        root,
	input  pla_vec_t                 in_vec,
	input  logic signed [COEF_W-1:0] kc,
	input  logic signed [COEF_W-1:0] kl,
	input  logic signed [COEF_W-1:0] kq,
	output logic                     out_valid,
	output pla_att_t                 att,
	output pla_vec_t                 out_vec,
	output logic [ROOT_W-1:0]        out_root
);
	logic vld_s1, vld_s2, vld_s3;
	logic [DIST_W-1:0] dist_c, dist_s1, dist_s2;
	logic [SQ_W-1:0] dd_s1;
	logic signed [COEF_W+DIST_W:0] klp_s1, klp_s2, pl_s2, ph_s2;
	logic signed [ATT_W-1:0] a_c;
	pla_vec_t vec_s1, vec_s2, vec_s3;
	logic [ROOT_W-1:0] root_s1, root_s2, root_s3;
	pla_att_t att_s3;

	// Distance saturates once the root reaches 2^32 in Q16.16.
	assign dist_c = (root[ROOT_W-1:DIST_SHIFT+DIST_W] != '0) ? '1
		: root[DIST_SHIFT +: DIST_W];

	assign a_c = (ATT_W'(kc) <<< 32) + (ATT_W'(klp_s2) <<< 16) + ATT_W'(pl_s2)
		+ (ATT_W'(ph_s2) <<< 32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s1 <= dist_c;
			dd_s1   <= dist_c * dist_c;
			klp_s1  <= kl * $signed({1'b0, dist_c});
			vec_s1  <= in_vec;
			root_s1 <= root;

			pl_s2   <= kq * $signed({1'b0, dd_s1[DIST_W-1:0]});
			ph_s2   <= kq * $signed({1'b0, dd_s1[SQ_W-1:DIST_W]});
			klp_s2  <= klp_s1;
			dist_s2 <= dist_s1;
			vec_s2  <= vec_s1;
			root_s2 <= root_s1;

			att_s3.nonpos   <= a_c[ATT_W-1] | (a_c == '0);
			att_s3.big      <= a_c[ATT_W-1:ATT_DEN_W] != '0;
			att_s3.den      <= a_c[ATT_DEN_W-1:0];
			att_s3.dist_sat <= dist_s2;
			vec_s3          <= vec_s2;
			root_s3         <= root_s2;
		end
	end

	assign out_valid = vld_s3;
	assign att       = att_s3;
	assign out_vec   = vec_s3;
	assign out_root  = root_s3;

endmodule

FILE: rtl/core/pla_div.sv
// Pipelined restoring divider: three numerators over one shared divisor,
// one quotient bit per stage, with an overflow flag per lane. Depends on pla_pkg.
module pla_div import pla_pkg::*; #(
	parameter int NUM_W  = COL_NUM_W,
	parameter int DEN_W  = ATT_DEN_W,
	parameter int Q_W    = DIV_Q_W,
	parameter int SIDE_W = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [2:0][NUM_W-1:0]      num,
	input  logic [DEN_W-1:0]           den,
	input  logic [SIDE_W-1:0]          side,
	output logic                       out_valid,
	output logic [2:0][Q_W-1:0]        quo,
	output logic [2:0]                 sat,
	output logic [SIDE_W-1:0]          side_out
);
	localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic                  vld_s  [Q_W];
	logic [2:0][CW-1:0]    rem_s  [Q_W];
	logic [2:0][Q_W-1:0]   quo_s  [Q_W];
	logic [2:0]            sat_s  [Q_W];
	logic [DEN_W-1:0]      den_s  [Q_W];
	logic [SIDE_W-1:0]     side_s [Q_W];

	for (genvar j = 0; j < Q_W; j++) begin : g_stage
		localparam int K = Q_W - 1 - j;
		logic                vld_in;
		logic [2:0][CW-1:0]  rem_in;
		logic [2:0][Q_W-1:0] quo_in;
		logic [2:0]          sat_in;
		logic [DEN_W-1:0]    den_in;
		logic [SIDE_W-1:0]   side_in;
		logic [CW-1:0]       trial;
		logic [2:0][CW-1:0]  rem_nx;
		logic [2:0][Q_W-1:0] quo_nx;

		if (j == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < 3; l++) begin
					rem_in[l] = CW'(num[l]);
					quo_in[l] = '0;
					// A quotient of 2^Q_W or more does not fit.
					sat_in[l] = CW'(num[l] >> Q_W) >= CW'(den);
				end
			end
			assign vld_in  = in_valid;
			assign den_in  = den;
			assign side_in = side;
		end else begin : g_next
			assign vld_in  = vld_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign quo_in  = quo_s[j-1];
			assign sat_in  = sat_s[j-1];
			assign den_in  = den_s[j-1];
			assign side_in = side_s[j-1];
		end

		assign trial = CW'(den_in) << K;

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				if (rem_in[l] >= trial) begin
					rem_nx[l] = rem_in[l] - trial;
					quo_nx[l] = quo_in[l] | (Q_W'(1) << K);
				end else begin
					rem_nx[l] = rem_in[l];
					quo_nx[l] = quo_in[l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= rem_nx;
				quo_s[j]  <= quo_nx;
				sat_s[j]  <= sat_in;
				den_s[j]  <= den_in;
				side_s[j] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[Q_W-1];
	assign quo       = quo_s[Q_W-1];
	assign sat       = sat_s[Q_W-1];
	assign side_out  = side_s[Q_W-1];

endmodule

FILE: rtl/core/point_light_attenuation.sv
// Top level of the point light attenuation pipeline: configuration registers,
// vector and square stages, output register. Depends on pla_pkg, pla_sqrt,
// pla_atten and pla_div.
//
//   Channel   Handshake             Beat contents
//   --------  --------------------  ------------------------------------------
//   cfg       cfg_valid/cfg_ready   cfg_index, cfg_data (register write)
//   in        in_valid/in_ready     point_x, point_y, point_z
//   out       out_valid/out_ready   dir_x/y/z, distance, red/green/blue,
//                                   unattenuated
//
// One beat enters per cycle while the output register is not stalled; from input to
// output each passes three vector stages, 47 square root stages (one root bit each),
// three attenuation stages, 16 divider stages (one quotient bit each) and the output register.
// All stages move together; when the output register holds an untaken beat
// the whole pipeline freezes and in_ready drops, so nothing is lost or repeated.
// Reset clears every valid bit and loads the configuration reset values.
// cfg_ready is always high; writes belong to idle periods.
module point_light_attenuation import pla_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] point_z,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [DIR_W-1:0] dir_x,
	output logic signed [DIR_W-1:0] dir_y,
	output logic signed [DIR_W-1:0] dir_z,
	output logic [DIST_W-1:0]      distance,
	output logic [CH_W-1:0]        red,
	output logic [CH_W-1:0]        green,
	output logic [CH_W-1:0]        blue,
	output logic                   unattenuated
);
	// Configuration registers.
	logic signed [COORD_W-1:0] light_x_q, light_y_q, light_z_q;
	logic [RGB_W-1:0]          intensity_q;
	logic signed [COEF_W-1:0]  kc_q, kl_q, kq_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x_q   <= '0;
			light_y_q   <= '0;
			light_z_q   <= '0;
			intensity_q <= INTENSITY_RST;
			kc_q        <= CONST_RST;
			kl_q        <= '0;
			kq_q        <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LIGHT_X:   light_x_q   <= cfg_data[COORD_W-1:0];
				REG_LIGHT_Y:   light_y_q   <= cfg_data[COORD_W-1:0];
				REG_LIGHT_Z:   light_z_q   <= cfg_data[COORD_W-1:0];
				REG_INTENSITY: intensity_q <= cfg_data[RGB_W-1:0];
				REG_CONST:     kc_q        <= cfg_data[COEF_W-1:0];
				REG_LINEAR:    kl_q        <= cfg_data[COEF_W-1:0];
				REG_QUAD:      kq_q        <= cfg_data[COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Global advance: the output register is empty or being drained.
	logic en;
	logic out_valid_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// Stage 1: exact 33-bit differences, split into magnitude and sign.
	logic [2:0][COORD_W:0] diff_c;
	pla_vec_t vec_c, vec_s1, vec_s2, vec_s3;
	logic vld_s1, vld_s2, vld_s3;
	logic [2:0][SQ_W-1:0] sq_s2;
	logic [SUM_W-1:0] sum_s3;

	assign diff_c[0] = {light_x_q[COORD_W-1], light_x_q} - {point_x[COORD_W-1], point_x};
	assign diff_c[1] = {light_y_q[COORD_W-1], light_y_q} - {point_y[COORD_W-1], point_y};
	assign diff_c[2] = {light_z_q[COORD_W-1], light_z_q} - {point_z[COORD_W-1], point_z};

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			vec_c.neg[l] = diff_c[l][COORD_W];
			// The magnitude never exceeds 2^32 - 1, so the low bits hold it.
			vec_c.mag[l] = vec_c.neg[l] ? MAG_W'(-diff_c[l]) : MAG_W'(diff_c[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 2 squares each magnitude, stage 3 adds the squares exactly.
	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= vec_c;
			for (int l = 0; l < 3; l++) begin
				sq_s2[l] <= vec_s1.mag[l] * vec_s1.mag[l];
			end
			vec_s2 <= vec_s1;
			sum_s3 <= SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
			vec_s3 <= vec_s2;
		end
	end

	// Length with 30 fraction bits: floor(sqrt(S * 2^28)).
	logic              sq_valid;
	logic [ROOT_W-1:0] sq_root;
	pla_vec_t          sq_vec;

	pla_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.rad       (RAD_W'(sum_s3) << SQRT_SHIFT),
		.in_vec    (vec_s3),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_vec   (sq_vec)
	);

	logic              at_valid;
	pla_att_t          at_att;
	pla_vec_t          at_vec;
	logic [ROOT_W-1:0] at_root;

	pla_atten u_atten (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.root      (sq_root),
		.in_vec    (sq_vec),
		.kc        (kc_q),
		.kl        (kl_q),
		.kq        (kq_q),
		.out_valid (at_valid),
		.att       (at_att),
		.out_vec   (at_vec),
		.out_root  (at_root)
	);

	// Direction: |D| * 2^28 / R per axis.
	localparam int DSIDE_W = 4;
	logic [2:0][DIR_NUM_W-1:0] dnum_c;
	logic                      dv;
	logic [2:0][DIV_Q_W-1:0]   dquo;
	logic [2:0]                dsat;
	logic [DSIDE_W-1:0]        dside;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			dnum_c[l] = DIR_NUM_W'(at_vec.mag[l]) << SQRT_SHIFT;
		end
	end

	pla_div #(
		.NUM_W  (DIR_NUM_W),
		.DEN_W  (ROOT_W),
		.Q_W    (DIV_Q_W),
		.SIDE_W (DSIDE_W)
	) u_div_dir (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (at_valid),
		.num       (dnum_c),
		.den       (at_root),
		.side      ({at_root == '0, at_vec.neg}),
		.out_valid (dv),
		.quo       (dquo),
		.sat       (dsat),
		.side_out  (dside)
	);

	// Colour: channel * 2^48 / A, red in the top bits of the intensity.
	localparam int CSIDE_W = 2 + DIST_W;
	logic [2:0][COL_NUM_W-1:0] cnum_c;
	logic [2:0][CH_W-1:0]      raw_c;
	logic                      cv;
	logic [2:0][DIV_Q_W-1:0]   cquo;
	logic [2:0]                csat;
	logic [CSIDE_W-1:0]        cside;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			raw_c[l]  = intensity_q[RGB_W-1-CH_W*l -: CH_W];
			cnum_c[l] = COL_NUM_W'(raw_c[l]) << COL_SHIFT;
		end
	end

	pla_div #(
		.NUM_W  (COL_NUM_W),
		.DEN_W  (ATT_DEN_W),
		.Q_W    (DIV_Q_W),
		.SIDE_W (CSIDE_W)
	) u_div_col (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (at_valid),
		.num       (cnum_c),
		.den       (at_att.den),
		.side      ({at_att.nonpos, at_att.big, at_att.dist_sat}),
		.out_valid (cv),
		.quo       (cquo),
		.sat       (csat),
		.side_out  (cside)
	);

	// Output register: clamping, sign and pass-through selection.
	logic [2:0][DIR_W-1:0] dir_c, dir_q;
	logic [2:0][CH_W-1:0]  col_c, col_q;
	logic [DIST_W-1:0]     dist_q;
	logic                  unatt_q;
	logic [DIR_W-1:0]      dmag;
	logic                  c_nonpos, c_big;

	assign c_nonpos = cside[CSIDE_W-1];
	assign c_big    = cside[CSIDE_W-2];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			// A point on the light has no direction; rounding past unity clamps.
			if (dside[DSIDE_W-1]) begin
				dmag = '0;
			end else if (dsat[l] || dquo[l] > DIV_Q_W'(DIR_ONE)) begin
				dmag = DIR_W'(DIR_ONE);
			end else begin
				dmag = DIR_W'(dquo[l]);
			end
			dir_c[l] = dside[l] ? -dmag : dmag;

			if (c_nonpos) begin
				col_c[l] = raw_c[l];
			end else if (c_big) begin
				col_c[l] = '0;
			end else if (csat[l]) begin
				col_c[l] = '1;
			end else begin
				col_c[l] = CH_W'(cquo[l]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv && cv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dir_q   <= dir_c;
			col_q   <= col_c;
			dist_q  <= cside[DIST_W-1:0];
			unatt_q <= c_nonpos;
		end
	end

	assign out_valid    = out_valid_q;
	assign dir_x        = dir_q[0];
	assign dir_y        = dir_q[1];
	assign dir_z        = dir_q[2];
	assign distance     = dist_q;
	assign red          = col_q[0];
	assign green        = col_q[1];
	assign blue         = col_q[2];
	assign unattenuated = unatt_q;

endmodule

FILE: rtl/core/pla_checker.sv
// Port-level checks of the point light attenuation block and their binding.
// Depends on pla_pkg and point_light_attenuation.
module pla_port_checks import pla_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic [CFG_IDX_W-1:0]   cfg_index,
	input logic [CFG_DATA_W-1:0]  cfg_data,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic [COORD_W-1:0]     point_x,
	input logic [COORD_W-1:0]     point_y,
	input logic [COORD_W-1:0]     point_z,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [DIR_W-1:0]       dir_x,
	input logic [DIR_W-1:0]       dir_y,
	input logic [DIR_W-1:0]       dir_z,
	input logic [DIST_W-1:0]      distance,
	input logic [CH_W-1:0]        red,
	input logic [CH_W-1:0]        green,
	input logic [CH_W-1:0]        blue,
	input logic                   unattenuated
);
	// A stalled result beat stays and keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(dir_x)
		&& $stable(red) && $stable(unattenuated))
		else $error("stalled result beat changed");

	// An empty output register never blocks the input.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked while output is empty");

	// Direction components never exceed unit length.
	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(dir_x) <= DIR_ONE) && ($signed(dir_x) >= -DIR_ONE)
		&& ($signed(dir_y) <= DIR_ONE) && ($signed(dir_y) >= -DIR_ONE)
		&& ($signed(dir_z) <= DIR_ONE) && ($signed(dir_z) >= -DIR_ONE))
		else $error("direction component beyond unity");

	// A zero direction only comes from a point on the light.
	a_zero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dir_x == '0 && dir_y == '0 && dir_z == '0 |-> distance == '0)
		else $error("zero direction with nonzero distance");

endmodule

bind point_light_attenuation pla_port_checks u_pla_port_checks (.*);
